// File: rtl/core/tpc_pkg.sv
// tpc_pkg: sizes, op codes and word types of the trie prefix counter
// no dependencies; used by trie_prefix_counter_core and the testbench
package tpc_pkg;

	localparam int NODES       = 4096;
	localparam int NODE_W      = 12;
	localparam int FREE_W      = 13;
	localparam int ALPHABET    = 26;
	localparam int LETTER_W    = 5;
	localparam int COUNT_BITS  = 20;
	localparam int OUT_W       = 20;
	localparam int CHILD_DEPTH = NODES * ALPHABET;
	localparam int CHILD_AW    = 17;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef struct packed {
		logic                op;
		logic [LETTER_W-1:0] letter;
		logic                last;
	} in_word_t;

	typedef struct packed {
		logic [OUT_W-1:0] prefix_count;
		logic             overflow;
	} out_word_t;

endpackage

// File: rtl/core/trie_prefix_counter_core.sv
// trie_prefix_counter_core: prefix-count trie, child pointer and count memories
// depends on tpc_pkg
//
//  channel | signals                       | word
//  in      | in_valid, in_ready, in_data   | op, letter, last (one letter)
//  out     | out_valid, out_ready, out_data| prefix_count, overflow
//
// each letter: child memory read, then for an existing child a count memory read
// (on query only for the last letter) and, on insert, a write back
// after reset a clearing pass over every child slot zeroes both memories, in_ready low
// one result word per word whose last letter arrives; it is held in an output
// register, and a finishing letter waits only while that register is still full
module trie_prefix_counter_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tpc_pkg::in_word_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output tpc_pkg::out_word_t out_data
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_CNT  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	localparam logic [tpc_pkg::CHILD_AW-1:0] CLR_LAST =
		tpc_pkg::CHILD_AW'(tpc_pkg::CHILD_DEPTH - 1);

	logic [tpc_pkg::NODE_W-1:0]     child_mem [tpc_pkg::CHILD_DEPTH];
	logic [tpc_pkg::COUNT_BITS-1:0] count_mem [tpc_pkg::NODES];

	logic [2:0]                     state_q;
	logic [tpc_pkg::CHILD_AW-1:0]   clr_q;
	logic [tpc_pkg::NODE_W-1:0]     cursor_q;
	logic                           failed_q;
	logic                           ovf_q;
	logic [tpc_pkg::FREE_W-1:0]     free_q;
	logic                           out_valid_q;
	tpc_pkg::out_word_t             out_q;

	logic                           op_q;
	logic                           last_q;
	logic [tpc_pkg::CHILD_AW-1:0]   slot_q;

	logic [tpc_pkg::NODE_W-1:0]     child_rd;
	logic [tpc_pkg::COUNT_BITS-1:0] count_rd;

	logic                           child_re;
	logic [tpc_pkg::CHILD_AW-1:0]   child_raddr;
	logic                           child_we;
	logic [tpc_pkg::CHILD_AW-1:0]   child_waddr;
	logic [tpc_pkg::NODE_W-1:0]     child_wdata;
	logic                           count_re;
	logic                           count_we;
	logic [tpc_pkg::NODE_W-1:0]     count_waddr;
	logic [tpc_pkg::COUNT_BITS-1:0] count_wdata;

	logic                           accept;
	logic                           pool_left;
	logic                           out_free;
	logic [tpc_pkg::COUNT_BITS-1:0] count_inc;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;
	assign pool_left = (free_q < tpc_pkg::FREE_W'(tpc_pkg::NODES));
	assign count_inc = (count_rd == tpc_pkg::COUNT_MAX) ? count_rd : count_rd + 1'b1;

	assign child_raddr = tpc_pkg::CHILD_AW'(cursor_q * tpc_pkg::CHILD_AW'(tpc_pkg::ALPHABET))
		+ tpc_pkg::CHILD_AW'(in_data.letter);

	// memory port control
	always_comb begin
		child_re    = 1'b0;
		child_we    = 1'b0;
		child_waddr = slot_q;
		child_wdata = free_q[tpc_pkg::NODE_W-1:0];
		count_re    = 1'b0;
		count_we    = 1'b0;
		count_waddr = cursor_q;
		count_wdata = count_inc;
		unique case (state_q)
			ST_CLR: begin
				child_we    = 1'b1;
				child_waddr = clr_q;
				child_wdata = '0;
				count_we    = (clr_q < tpc_pkg::CHILD_AW'(tpc_pkg::NODES));
				count_waddr = clr_q[tpc_pkg::NODE_W-1:0];
				count_wdata = '0;
			end
			ST_IDLE: begin
				child_re = accept && !failed_q
					&& (in_data.letter < tpc_pkg::LETTER_W'(tpc_pkg::ALPHABET));
			end
			ST_RD: begin
				if (op_q == tpc_pkg::OP_INSERT) begin
					if (child_rd == '0) begin
						// fresh node: its count was zero, so it becomes one
						child_we    = pool_left;
						count_we    = pool_left;
						count_waddr = free_q[tpc_pkg::NODE_W-1:0];
						count_wdata = tpc_pkg::COUNT_BITS'(1);
					end else begin
						count_re = 1'b1;
					end
				end else begin
					count_re = (child_rd != '0) && last_q;
				end
			end
			ST_CNT: begin
				count_we = (op_q == tpc_pkg::OP_INSERT);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (child_we) begin
			child_mem[child_waddr] <= child_wdata;
		end
		if (child_re) begin
			child_rd <= child_mem[child_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (count_we) begin
			count_mem[count_waddr] <= count_wdata;
		end
		if (count_re) begin
			count_rd <= count_mem[child_rd];
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_data.op;
			last_q <= in_data.last;
			slot_q <= child_raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			cursor_q    <= '0;
			failed_q    <= 1'b0;
			ovf_q       <= 1'b0;
			free_q      <= tpc_pkg::FREE_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (failed_q) begin
							state_q <= ST_FIN;
						end else if (in_data.letter >=
							tpc_pkg::LETTER_W'(tpc_pkg::ALPHABET)) begin
							failed_q <= 1'b1;
							state_q  <= ST_FIN;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					if (op_q == tpc_pkg::OP_INSERT) begin
						if (child_rd == '0) begin
							if (pool_left) begin
								cursor_q <= free_q[tpc_pkg::NODE_W-1:0];
								free_q   <= free_q + 1'b1;
							end else begin
								failed_q <= 1'b1;
								ovf_q    <= 1'b1;
							end
							state_q <= ST_FIN;
						end else begin
							cursor_q <= child_rd;
							state_q  <= ST_CNT;
						end
					end else begin
						if (child_rd == '0) begin
							failed_q <= 1'b1;
							state_q  <= ST_FIN;
						end else begin
							cursor_q <= child_rd;
							state_q  <= last_q ? ST_CNT : ST_FIN;
						end
					end
				end
				ST_CNT: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						cursor_q    <= '0;
						failed_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result word; query count is still in the count read register
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && last_q && out_free) begin
			out_q.prefix_count <= (op_q == tpc_pkg::OP_QUERY && !failed_q)
				? tpc_pkg::OUT_W'(count_rd) : '0;
			out_q.overflow     <= ovf_q;
		end
	end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// testbench: directed and random letter traffic for trie_prefix_counter_core
// depends on tpc_pkg and the core; predicts each result word with its own trie copy
module testbench;
	import tpc_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;

	trie_prefix_counter_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// trie copy used for prediction
	logic [NODE_W-1:0]     kid_tab [CHILD_DEPTH];
	logic [COUNT_BITS-1:0] cnt_tab [NODES];
	logic [NODE_W-1:0]     cursor;
	logic                  dropped;
	logic                  ovf_seen;
	int                    free_ptr;

	out_word_t due_results [$];
	out_word_t head;

	int mismatches;
	int letters_sent;
	int gap_pct;
	int stall_pct;

	// inserted words, replayed as query prefixes
	logic [LETTER_W-1:0] bank_ltr [128][12];
	int                  bank_len [128];
	int                  bank_n;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				$display("%0t: result word with none due: count %0d overflow %0b",
					$time, out_data.prefix_count, out_data.overflow);
				mismatches++;
			end else begin
				head = due_results.pop_front();
				if (out_data.prefix_count !== head.prefix_count) begin
					$display("%0t: prefix_count expected %0d actual %0d",
						$time, head.prefix_count, out_data.prefix_count);
					mismatches++;
				end
				if (out_data.overflow !== head.overflow) begin
					$display("%0t: overflow expected %0b actual %0b",
						$time, head.overflow, out_data.overflow);
					mismatches++;
				end
			end
		end
	end

	function automatic void add_through(input logic [NODE_W-1:0] n);
		if (cnt_tab[n] != COUNT_MAX)
			cnt_tab[n] = cnt_tab[n] + 1'b1;
	endfunction

	// one letter through the trie copy; a finishing letter queues its result word
	function automatic void walk_letter(input in_word_t w);
		int                slot;
		logic [NODE_W-1:0] nxt;
		out_word_t         r;
		if (!dropped) begin
			if (w.letter >= ALPHABET) begin
				dropped = 1'b1;
			end else begin
				slot = int'(cursor) * ALPHABET + int'(w.letter);
				nxt = kid_tab[slot];
				if (w.op == OP_INSERT) begin
					if (cursor == 0)
						add_through('0);
					if (nxt == 0) begin
						if (free_ptr < NODES) begin
							nxt = free_ptr[NODE_W-1:0];
							free_ptr++;
							kid_tab[slot] = nxt;
						end else begin
							dropped = 1'b1;
							ovf_seen = 1'b1;
						end
					end
					if (!dropped) begin
						add_through(nxt);
						cursor = nxt;
					end
				end else begin
					if (nxt == 0)
						dropped = 1'b1;
					else
						cursor = nxt;
				end
			end
		end
		if (w.last) begin
			r.prefix_count = (w.op == OP_QUERY && !dropped) ? cnt_tab[cursor] : '0;
			r.overflow = ovf_seen;
			due_results = {due_results, r};
			cursor = '0;
			dropped = 1'b0;
		end
	endfunction

	// starts and ends just after a falling edge; valid stays up between letters unless a gap is drawn
	task automatic send_letter(input logic op, input logic [LETTER_W-1:0] ltr,
			input logic last);
		in_word_t w;
		w.op = op;
		w.letter = ltr;
		w.last = last;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		walk_letter(w);
		letters_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [LETTER_W-1:0] rand_letter();
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return LETTER_W'($urandom_range(31, ALPHABET));
		else if (r < 80)
			return LETTER_W'($urandom_range(3));
		else
			return LETTER_W'($urandom_range(ALPHABET - 1));
	endfunction

	// mostly well-formed words over a small alphabet so prefixes get shared
	task automatic send_random_word();
		int                  len;
		int                  pick;
		int                  k;
		logic                op;
		logic                op_k;
		logic [LETTER_W-1:0] ltr;
		bit                  from_bank;
		if ($urandom_range(99) < 12) begin
			send_letter(1'($urandom_range(1)), LETTER_W'($urandom_range(31)),
				1'($urandom_range(1)));
			return;
		end
		op = ($urandom_range(99) < 55) ? OP_INSERT : OP_QUERY;
		from_bank = (op == OP_QUERY) && (bank_n > 0) && ($urandom_range(99) < 70);
		pick = 0;
		if (from_bank) begin
			pick = $urandom_range(((bank_n < 128) ? bank_n : 128) - 1);
			len = $urandom_range(bank_len[pick], 1);
		end else begin
			len = ($urandom_range(99) < 90) ? $urandom_range(5, 1) : $urandom_range(12, 6);
		end
		for (k = 0; k < len; k++) begin
			ltr = from_bank ? bank_ltr[pick][k] : rand_letter();
			if (from_bank && k == len - 1 && $urandom_range(99) < 20)
				ltr = rand_letter();
			op_k = ($urandom_range(99) < 5) ? ~op : op;
			if (!from_bank && op == OP_INSERT)
				bank_ltr[bank_n % 128][k] = ltr;
			send_letter(op_k, ltr, k == len - 1);
		end
		if (!from_bank && op == OP_INSERT) begin
			bank_len[bank_n % 128] = len;
			bank_n++;
		end
	endtask

	task automatic test_directed();
		gap_pct = 0;
		stall_pct = 0;
		send_letter(OP_QUERY, 0, 1'b1);
		send_letter(OP_INSERT, 0, 1'b0);
		send_letter(OP_INSERT, 1, 1'b0);
		send_letter(OP_INSERT, 2, 1'b1);
		send_letter(OP_INSERT, 0, 1'b0);
		send_letter(OP_INSERT, 1, 1'b1);
		send_letter(OP_QUERY, 0, 1'b1);
		send_letter(OP_QUERY, 0, 1'b0);
		send_letter(OP_QUERY, 1, 1'b0);
		send_letter(OP_QUERY, 2, 1'b1);
		// missing child on the way
		send_letter(OP_QUERY, 0, 1'b0);
		send_letter(OP_QUERY, 1, 1'b0);
		send_letter(OP_QUERY, 3, 1'b1);
		send_letter(OP_INSERT, 25, 1'b1);
		send_letter(OP_QUERY, 25, 1'b1);
		// out of range letter drops the rest of the word
		send_letter(OP_INSERT, 0, 1'b0);
		send_letter(OP_INSERT, 31, 1'b0);
		send_letter(OP_INSERT, 1, 1'b1);
		send_letter(OP_QUERY, 26, 1'b1);
		// mixed ops inside one word
		send_letter(OP_INSERT, 0, 1'b0);
		send_letter(OP_QUERY, 1, 1'b1);
		send_letter(OP_QUERY, 0, 1'b0);
		send_letter(OP_INSERT, 1, 1'b1);
		drain();
	endtask

	task automatic test_random(input int idle_in, input int stall_in, input int n);
		int start;
		gap_pct = idle_in;
		stall_pct = stall_in;
		start = letters_sent;
		while (letters_sent - start < n)
			send_random_word();
		drain();
	endtask

	initial begin
		for (int i = 0; i < CHILD_DEPTH; i++)
			kid_tab[i] = '0;
		for (int i = 0; i < NODES; i++)
			cnt_tab[i] = '0;
		cursor = '0;
		dropped = 1'b0;
		ovf_seen = 1'b0;
		free_ptr = 1;
		mismatches = 0;
		letters_sent = 0;
		bank_n = 0;
		gap_pct = 0;
		stall_pct = 0;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random(0, 0, 260);
		test_random(57, 0, 260);
		test_random(0, 57, 260);
		test_random(14, 14, 260);
		test_random(14, 14, 120);

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: files.f
rtl/core/tpc_pkg.sv
rtl/core/trie_prefix_counter_core.sv
tb/sv/testbench.sv
